// ----- rtl/core/rmpt_pkg.sv -----
// Package: shared constants and types for the min-plus tree sampler.
package rmpt_pkg;

  localparam int MaxDepth   = 16;
  localparam int AddrW      = MaxDepth;
  localparam int DepthW     = $clog2(MaxDepth + 1);
  localparam int NodeW      = 19;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [CfgIdxW-1:0] REG_DEPTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SUMTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KINDS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CUT0   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CUT1   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CUT2   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VALUES = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SEED   = 3'd7;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_M2 = 64'h94D049BB133111EB;

  // Generator unit operation codes
  localparam logic [1:0] GOP_IDLE = 2'd0;
  localparam logic [1:0] GOP_SEED = 2'd1;
  localparam logic [1:0] GOP_DRAW = 2'd2;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } gen_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } gen_rsp_t;

endpackage

// ----- rtl/core/rmpt_mul32.sv -----
// Shared 64-bit multiplier built from one 32x32 partial product per cycle.
module rmpt_mul32 import rmpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] a_r, b_r;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_r;
  logic [1:0]  pstep_r;
  logic        pv_r;
  logic        done_r;

  // Select the partial product for this step (low word product only needs three)
  always_comb begin
    case (step_r)
      2'd0:    begin op_a = a_r[31:0];  op_b = b_r[31:0];  end
      2'd1:    begin op_a = a_r[31:0];  op_b = b_r[63:32]; end
      2'd2:    begin op_a = a_r[63:32]; op_b = b_r[31:0];  end
      default: begin op_a = 32'd0;      op_b = 32'd0;      end
    endcase
  end

  // Advance the step counter
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (go) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      if (step_r == 2'd2) busy_nxt = 1'b0;
      step_nxt = step_r + 2'd1;
    end
  end

  // Accumulate the registered partial products
  always_comb begin
    acc_nxt = acc_r;
    if (pv_r) begin
      if (pstep_r == 2'd0) acc_nxt = prod_r;
      else acc_nxt = acc_r + {prod_r[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    prod_r  <= {32'd0, op_a} * {32'd0, op_b};
    pstep_r <= step_r;
    acc_r   <= acc_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      pv_r   <= busy_r && !go;
      done_r <= pv_r && pstep_r == 2'd2;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- rtl/core/rmpt_gen.sv -----
// Generator: xoshiro256++ state with splitmix64 reseed through the shared multiplier.
module rmpt_gen import rmpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gen_req_t    req,
  input  logic [63:0] seed,
  output gen_rsp_t    rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] g0_r, g1_r, g2_r, g3_r;
  logic [63:0] acc_r;
  logic [1:0]  widx_r;
  logic        done_r;
  logic [63:0] out_r;
  logic        mgo;
  logic [63:0] ma, mb, mp;
  logic        mdone;
  logic [63:0] sum03, d_out, t2, t3, t1, t0, t2b, fin;

  rmpt_mul32 u_mul (
    .clk(clk), .rst_n(rst_n), .go(mgo), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  // Draw path
  assign sum03 = g0_r + g3_r;
  assign d_out = {sum03[40:0], sum03[63:41]} + g0_r;
  assign t2    = g2_r ^ g0_r;
  assign t3    = g3_r ^ g1_r;
  assign t1    = g1_r ^ t2;
  assign t0    = g0_r ^ t3;
  assign t2b   = t2 ^ {g1_r[46:0], 17'd0};
  assign fin   = mp ^ (mp >> 31);

  assign mgo = (st_r == S_ADD) || (st_r == S_M1 && mdone);
  assign ma  = (st_r == S_ADD) ? (acc_r ^ (acc_r >> 30)) : (mp ^ (mp >> 27));
  assign mb  = (st_r == S_ADD) ? MIX_M1 : MIX_M2;

  // Sequence the splitmix expansion
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (req.go && req.op == GOP_SEED) st_nxt = S_ADD;
      S_ADD:   st_nxt = S_M1;
      S_M1:    if (mdone) st_nxt = S_M2;
      S_M2:    if (mdone) st_nxt = (widx_r == 2'd3) ? S_DONE : S_ADD;
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && req.go && req.op == GOP_SEED) acc_r <= seed + GOLDEN;
    if (st_r == S_M2 && mdone) acc_r <= acc_r + GOLDEN;
    if (req.go && req.op == GOP_DRAW && st_r == S_IDLE) out_r <= d_out;
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      widx_r <= 2'd0;
      g0_r <= '0; g1_r <= '0; g2_r <= '0; g3_r <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == S_IDLE && req.go && req.op == GOP_DRAW) || st_r == S_DONE;
      if (st_r == S_IDLE && req.go && req.op == GOP_SEED) widx_r <= 2'd0;
      if (st_r == S_M2 && mdone) begin
        widx_r <= widx_r + 2'd1;
        case (widx_r)
          2'd0:    g0_r <= fin;
          2'd1:    g1_r <= fin;
          2'd2:    g2_r <= fin;
          default: g3_r <= fin;
        endcase
      end
      if (st_r == S_IDLE && req.go && req.op == GOP_DRAW) begin
        g0_r <= t0;
        g1_r <= t1;
        g2_r <= t2b;
        g3_r <= {t3[18:0], t3[63:19]};
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = out_r;

endmodule

// ----- rtl/core/rmpt_seq.sv -----
// Sequencer: leaf fill and level-by-level reduction over the node memory.
module rmpt_seq import rmpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              reseed,
  input  logic [DepthW-1:0] depth,
  input  logic [2:0]        kinds,
  input  logic [63:0]       sum_th,
  input  logic [63:0]       cut0,
  input  logic [63:0]       cut1,
  input  logic [63:0]       cut2,
  input  logic [11:0]       values,
  output gen_req_t          greq,
  input  gen_rsp_t          grsp,
  output logic              busy,
  output logic              done,
  output logic [NodeW-1:0]  root
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEED  = 4'd1;
  localparam logic [3:0] S_LREQ  = 4'd2;
  localparam logic [3:0] S_LWAIT = 4'd3;
  localparam logic [3:0] S_RA    = 4'd4;
  localparam logic [3:0] S_RB    = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_RWR   = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [NodeW-1:0] mem [2**AddrW];
  logic [3:0]        st_r, st_nxt;
  logic [AddrW:0]    cnt_r;
  logic [AddrW:0]    lim_r;
  logic [NodeW-1:0]  rd_r, a_r, b_r;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [NodeW-1:0]  wr_data;
  logic [1:0]        lidx;
  logic [2:0]        leaf_v;
  logic              single;
  logic [NodeW-1:0]  red_v;
  logic              busy_r, done_r;
  logic [NodeW-1:0]  root_r;

  assign single = kinds <= 3'd1;

  // Leaf index from the draw
  always_comb begin
    if (single) lidx = 2'd0;
    else if (grsp.value < cut0) lidx = 2'd0;
    else if (kinds > 3'd2 && grsp.value < cut1) lidx = 2'd1;
    else if (kinds > 3'd3 && grsp.value < cut2) lidx = 2'd2;
    else lidx = 2'(kinds - 3'd1);
  end
  assign leaf_v = values[3*lidx +: 3];

  assign red_v = (grsp.value < sum_th) ? (a_r + b_r)
                                       : ((a_r < b_r) ? a_r : b_r);

  always_comb begin
    st_nxt  = st_r;
    greq    = '{go: 1'b0, op: GOP_IDLE};
    wr_en   = 1'b0;
    wr_addr = cnt_r[AddrW-1:0];
    wr_data = {16'd0, leaf_v};
    rd_addr = cnt_r[AddrW-1:0];
    case (st_r)
      S_IDLE: if (start) st_nxt = reseed ? S_SEED : S_LREQ;
      S_SEED: begin
        if (grsp.done) st_nxt = S_LREQ;
      end
      S_LREQ: begin
        if (single) begin
          wr_en = 1'b1;
          st_nxt = (cnt_r + 1'b1 == lim_r) ? (lim_r == 1 ? S_ROOT : S_RA) : S_LREQ;
        end else begin
          greq = '{go: 1'b1, op: GOP_DRAW};
          st_nxt = S_LWAIT;
        end
      end
      S_LWAIT: if (grsp.done) begin
        wr_en = 1'b1;
        st_nxt = (cnt_r + 1'b1 == lim_r) ? (lim_r == 1 ? S_ROOT : S_RA) : S_LREQ;
      end
      S_RA: begin
        rd_addr = {cnt_r[AddrW-2:0], 1'b0};
        st_nxt = S_RB;
      end
      S_RB: begin
        rd_addr = {cnt_r[AddrW-2:0], 1'b1};
        greq = '{go: 1'b1, op: GOP_DRAW};
        st_nxt = S_RWAIT;
      end
      S_RWAIT: if (grsp.done) st_nxt = S_RWR;
      S_RWR: begin
        wr_en = 1'b1;
        wr_data = red_v;
        st_nxt = (cnt_r + 1'b1 == lim_r) ? (lim_r == 1 ? S_ROOT : S_RA) : S_RA;
      end
      S_ROOT: begin
        rd_addr = '0;
        st_nxt = S_OUT;
      end
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE && start && reseed) greq = '{go: 1'b1, op: GOP_SEED};
  end

  // Node memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RB) a_r <= rd_r;
    if (st_r == S_RWAIT && grsp.done) b_r <= rd_r;
    if (st_r == S_RWAIT && !grsp.done && b_r != rd_r) b_r <= rd_r;
    if (!rst_n) begin
      st_r   <= S_IDLE;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      lim_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= st_r == S_OUT;
      if (st_r == S_OUT) root_r <= rd_r;
      busy_r <= (st_nxt != S_IDLE);
      if (st_r == S_IDLE && start) begin
        cnt_r <= '0;
        lim_r <= (AddrW+1)'(1) << depth;
      end
      if ((st_r == S_LREQ && single) || (st_r == S_LWAIT && grsp.done)) begin
        if (cnt_r + 1'b1 == lim_r) begin
          cnt_r <= '0;
          lim_r <= lim_r >> 1;
        end else cnt_r <= cnt_r + 1'b1;
      end
      if (st_r == S_RWR) begin
        if (cnt_r + 1'b1 == lim_r) begin
          cnt_r <= '0;
          lim_r <= lim_r >> 1;
        end else cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/core/random_min_plus_tree_sampler_core.sv -----
// Top level: configuration registers, generator and tree sequencer.
// One start transfer yields one out_root_value strobe, held by out_valid for one
// cycle; the receiver cannot stall it. A sample fills 2^depth leaves with one
// draw each (no draw is taken when only one leaf kind is set), then runs
// 2^depth-1 reductions, each reading two nodes, taking a draw and writing the
// result, and reads out the root; a reseed adds the four splitmix words, each
// needing two 64-bit products of three 32x32 partial products on the one
// multiplier. Depth is saturated to 16, leaf kinds to 1..4; the node memory
// needs no clearing pass.
module random_min_plus_tree_sampler_core import rmpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_reseed,
  output logic                out_valid,
  output logic [NodeW-1:0]    out_root_value,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [4:0]  depth_r;
  logic [63:0] sumth_r, cut0_r, cut1_r, cut2_r, seed_r;
  logic [2:0]  kinds_r;
  logic [11:0] values_r;
  logic [DepthW-1:0] depth_s;
  logic [2:0]  kinds_s;
  gen_req_t    greq;
  gen_rsp_t    grsp;
  logic        seq_busy;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 5'd1; sumth_r <= '0; kinds_r <= 3'd1;
      cut0_r <= '0; cut1_r <= '0; cut2_r <= '0;
      values_r <= 12'd1; seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH:  depth_r  <= cfg_data[4:0];
        REG_SUMTH:  sumth_r  <= cfg_data;
        REG_KINDS:  kinds_r  <= cfg_data[2:0];
        REG_CUT0:   cut0_r   <= cfg_data;
        REG_CUT1:   cut1_r   <= cfg_data;
        REG_CUT2:   cut2_r   <= cfg_data;
        REG_VALUES: values_r <= cfg_data[11:0];
        REG_SEED:   seed_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate depth and kinds
  assign depth_s = (depth_r > 5'(MaxDepth)) ? DepthW'(MaxDepth) : DepthW'(depth_r);
  assign kinds_s = (kinds_r == 3'd0) ? 3'd1 : ((kinds_r > 3'd4) ? 3'd4 : kinds_r);

  rmpt_gen u_gen (.clk(clk), .rst_n(rst_n), .req(greq), .seed(seed_r), .rsp(grsp));

  rmpt_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start && !busy), .reseed(in_reseed),
    .depth(depth_s), .kinds(kinds_s), .sum_th(sumth_r),
    .cut0(cut0_r), .cut1(cut1_r), .cut2(cut2_r), .values(values_r),
    .greq(greq), .grsp(grsp), .busy(seq_busy), .done(out_valid),
    .root(out_root_value)
  );

  assign busy = seq_busy;

endmodule

// ----- rtl/core/rmpt_checker.sv -----
// Checker: port-level properties of the sampler, bound to the top level.
module rmpt_checker import rmpt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy fell without result");

endmodule

bind random_min_plus_tree_sampler_core rmpt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
